// ===== rtl/core/crcdf_pkg.sv =====
`default_nettype none
package crcdf_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);
  localparam logic [15:0] CrcPoly = 16'h1021;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_MAX_LEN     = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_GOOD   = 2'd2,
    KIND_BAD    = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  msg_id;
    logic [7:0]  msg_len;
    logic [7:0]  data;
    logic [31:0] time_us;
  } op_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/crcdf_front.sv =====
`default_nettype none
module crcdf_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [7:0]                    rx_byte_i,
  input  wire logic [31:0]                   time_us_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [crcdf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]                    cfg_data_i,
  output logic                               push_o,
  output crcdf_pkg::op_t                     op_o
);

  typedef enum logic [2:0] {
    PH_SYNC1   = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_ID      = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRCLO   = 3'd5,
    PH_CRCHI   = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  sync_first_q, sync_second_q, max_len_q;
  logic [7:0]  id_q, id_d, len_q, len_d, cnt_q, cnt_d, crc_lo_q, crc_lo_d;
  logic [15:0] crc_q, crc_d, crc_upd;
  logic [7:0]  cnt_inc;

  assign crc_upd = crcdf_pkg::crc_add(crc_q, rx_byte_i);
  assign cnt_inc = cnt_q + 8'd1;

  always_comb begin
    phase_d  = phase_q;
    id_d     = id_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    push_o   = 1'b0;
    op_o     = '{kind: crcdf_pkg::KIND_HEADER, msg_id: id_q, msg_len: len_q,
                 data: 8'h00, time_us: time_us_i};
    if (accept_i) begin
      unique case (phase_q)
        PH_SYNC2: begin
          if (rx_byte_i == sync_second_q) begin
            crc_d   = crc_upd;
            phase_d = PH_ID;
          end else begin
            phase_d = PH_SYNC1;
          end
        end
        PH_ID: begin
          id_d    = rx_byte_i;
          crc_d   = crc_upd;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          len_d = rx_byte_i;
          cnt_d = 8'h00;
          if (rx_byte_i > max_len_q) begin
            phase_d = PH_SYNC1;
          end else begin
            crc_d          = crc_upd;
            phase_d        = (rx_byte_i != 8'h00) ? PH_PAYLOAD : PH_CRCLO;
            push_o         = 1'b1;
            op_o.msg_len   = rx_byte_i;
          end
        end
        PH_PAYLOAD: begin
          crc_d = crc_upd;
          cnt_d = cnt_inc;
          if (cnt_inc >= len_q) begin
            phase_d = PH_CRCLO;
          end
          push_o    = 1'b1;
          op_o.kind = crcdf_pkg::KIND_DATA;
          op_o.data = rx_byte_i;
        end
        PH_CRCLO: begin
          crc_lo_d = rx_byte_i;
          phase_d  = PH_CRCHI;
        end
        PH_CRCHI: begin
          phase_d   = PH_SYNC1;
          push_o    = 1'b1;
          op_o.kind = ({rx_byte_i, crc_lo_q} == crc_q) ? crcdf_pkg::KIND_GOOD
                                                      : crcdf_pkg::KIND_BAD;
        end
        default: begin
          phase_d = PH_SYNC1;
          if (rx_byte_i == sync_first_q) begin
            crc_d   = crcdf_pkg::crc_add(16'h0000, rx_byte_i);
            phase_d = PH_SYNC2;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_SYNC1;
      id_q          <= 8'h00;
      len_q         <= 8'h00;
      cnt_q         <= 8'h00;
      crc_q         <= 16'h0000;
      crc_lo_q      <= 8'h00;
      sync_first_q  <= 8'h00;
      sync_second_q <= 8'h00;
      max_len_q     <= 8'hFF;
    end else begin
      phase_q  <= phase_d;
      id_q     <= id_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
      if (cfg_we_i) begin
        unique case (crcdf_pkg::cfg_idx_e'(cfg_index_i))
          crcdf_pkg::CFG_SYNC_FIRST:  sync_first_q  <= cfg_data_i;
          crcdf_pkg::CFG_SYNC_SECOND: sync_second_q <= cfg_data_i;
          crcdf_pkg::CFG_MAX_LEN:     max_len_q     <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/crcdf_queue.sv =====
`default_nettype none
module crcdf_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire crcdf_pkg::op_t push_op_i,
  input  wire logic           pop_i,
  output crcdf_pkg::op_t      head_op_o,
  output logic                empty_o,
  output logic                full_o
);

  crcdf_pkg::op_t                       mem_q [crcdf_pkg::QueueDepth];
  logic [crcdf_pkg::QueuePtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [crcdf_pkg::QueueCntW-1:0]      count_q;

  assign empty_o   = (count_q == '0);
  assign full_o    = (count_q == crcdf_pkg::QueueCntW'(crcdf_pkg::QueueDepth));
  assign head_op_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/crcdf_back.sv =====
`default_nettype none
module crcdf_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire crcdf_pkg::op_t head_op_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [1:0]          kind_o,
  output logic [7:0]          msg_id_o,
  output logic [7:0]          msg_len_o,
  output logic [7:0]          data_o,
  output logic [31:0]         crc_failures_o,
  output logic [31:0]         heard_time_us_o,
  output logic                frame_last_o
);

  logic        valid_q;
  logic [31:0] fail_q, fail_d, heard_q, heard_d;
  logic [1:0]  kind_q;
  logic [7:0]  id_q, len_q, data_q;

  assign pop_o = !empty_i && (!valid_q || !out_stall_i);

  always_comb begin
    fail_d  = fail_q;
    heard_d = heard_q;
    if (head_op_i.kind == crcdf_pkg::KIND_BAD) begin
      fail_d = fail_q + 32'd1;
    end
    if (head_op_i.kind == crcdf_pkg::KIND_GOOD) begin
      heard_d = head_op_i.time_us;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      fail_q  <= 32'd0;
      heard_q <= 32'd0;
    end else begin
      if (pop_o) begin
        valid_q <= 1'b1;
        fail_q  <= fail_d;
        heard_q <= heard_d;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= head_op_i.kind;
      id_q   <= head_op_i.msg_id;
      len_q  <= head_op_i.msg_len;
      data_q <= head_op_i.data;
    end
  end

  assign out_valid_o     = valid_q;
  assign kind_o          = kind_q;
  assign msg_id_o        = id_q;
  assign msg_len_o       = len_q;
  assign data_o          = data_q;
  assign crc_failures_o  = fail_q;
  assign heard_time_us_o = heard_q;
  assign frame_last_o    = kind_q[1];

endmodule
`default_nettype wire

// ===== rtl/core/crc16_packet_deframer_unit.sv =====
// A result is written into the queue when its byte is transferred and is then
// registered in the output stage when no earlier result waits ahead of it.
// Throughput: one byte per cycle while the queue is not full.
// A four-entry queue between the parser and the output stage absorbs output stalls.
// Reset is asynchronous and active low; it restores the configuration defaults and
// the search for the first sync byte and clears the failure count and last time.
`default_nettype none
module crc16_packet_deframer_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    rx_byte_i,
  input  wire logic [31:0]                   time_us_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [crcdf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]                    cfg_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         kind_o,
  output logic [7:0]                         msg_id_o,
  output logic [7:0]                         msg_len_o,
  output logic [7:0]                         data_o,
  output logic [31:0]                        crc_failures_o,
  output logic [31:0]                        heard_time_us_o,
  output logic                               frame_last_o
);

  logic           accept, push, pop, empty, full;
  crcdf_pkg::op_t push_op, head_op;

  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;
  assign cfg_ready_o = 1'b1;

  crcdf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .time_us_i   (time_us_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .op_o        (push_op)
  );

  crcdf_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (pop),
    .head_op_o (head_op),
    .empty_o   (empty),
    .full_o    (full)
  );

  crcdf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_op_i       (head_op),
    .empty_i         (empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .msg_id_o        (msg_id_o),
    .msg_len_o       (msg_len_o),
    .data_o          (data_o),
    .crc_failures_o  (crc_failures_o),
    .heard_time_us_o (heard_time_us_o),
    .frame_last_o    (frame_last_o)
  );

endmodule
`default_nettype wire
